// File: src/assert_macros.svh
// Assertion macro used by the top-level RTL file of the sparse index table.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define MSIT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

`endif

// File: src/msit_pkg.sv
// Shared types, constants and helper functions of the sparse index table.
// Used by msit_step, the top level and the testbench.
`default_nettype none
package msit_pkg;
  localparam int MAX_LEVELS = 4;
  localparam int MAX_BRANCH = 16;
  localparam int DIGIT_BITS = 4;
  localparam int VALUE_BITS = 32;
  localparam int ADDR_BITS  = DIGIT_BITS * MAX_LEVELS;
  localparam int LVL_BITS   = 3;
  localparam int BR_BITS    = 5;

  typedef logic [DIGIT_BITS-1:0]       digit_t;
  typedef digit_t [MAX_LEVELS-1:0]     digits_t;
  typedef logic [BR_BITS-1:0]          branch_t;
  typedef branch_t [MAX_LEVELS-1:0]    branches_t;
  typedef logic [LVL_BITS-1:0]         level_t;
  typedef logic [ADDR_BITS-1:0]        addr_t;
  typedef logic [VALUE_BITS-1:0]       value_t;

  typedef enum logic [2:0] {
    KIND_READ  = 3'd0,
    KIND_WRITE = 3'd1,
    KIND_ERASE = 3'd2,
    KIND_NEXT  = 3'd3,
    KIND_PREV  = 3'd4,
    KIND_CLEAR = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    REG_LEVELS = 3'd0,
    REG_BR0    = 3'd1,
    REG_BR1    = 3'd2,
    REG_BR2    = 3'd3,
    REG_BR3    = 3'd4
  } reg_e;

  function automatic level_t eff_levels(input level_t l);
    level_t r;
    r = l;
    if (l < level_t'(1)) r = level_t'(1);
    if (l > level_t'(MAX_LEVELS)) r = level_t'(MAX_LEVELS);
    return r;
  endfunction

  function automatic branch_t eff_branch(input branch_t b);
    branch_t r;
    r = b;
    if (b < branch_t'(2)) r = branch_t'(2);
    if (b > branch_t'(MAX_BRANCH)) r = branch_t'(MAX_BRANCH);
    return r;
  endfunction
endpackage
`default_nettype wire

// File: src/msit_ram.sv
// Single-port store with registered read data.
// Generic; no package dependency.
`default_nettype none
module msit_ram #(
  parameter int AW = 16,
  parameter int DW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

// File: src/msit_step.sv
// Shared stepper: moves a mixed-radix index one place forward or back.
// Depends on msit_pkg.
`default_nettype none
module msit_step (
  input  wire msit_pkg::digits_t   dig_i,
  input  wire msit_pkg::level_t    levels_i,
  input  wire msit_pkg::branches_t branch_i,
  input  wire logic                fwd_i,
  output msit_pkg::digits_t        dig_o,
  output logic                     ok_o
);
  always_comb begin
    logic carry;
    msit_pkg::branch_t nxt;
    carry = 1'b1;
    dig_o = dig_i;
    for (int i = msit_pkg::MAX_LEVELS - 1; i >= 0; i--) begin
      nxt = msit_pkg::branch_t'(dig_i[i]) + msit_pkg::branch_t'(1);
      if (carry && (msit_pkg::level_t'(i) < levels_i)) begin
        if (fwd_i) begin
          if (nxt < branch_i[i]) begin
            dig_o[i] = nxt[msit_pkg::DIGIT_BITS-1:0];
            carry = 1'b0;
          end else begin
            dig_o[i] = '0;
          end
        end else begin
          if (dig_i[i] != '0) begin
            dig_o[i] = dig_i[i] - msit_pkg::digit_t'(1);
            carry = 1'b0;
          end else begin
            dig_o[i] = msit_pkg::digit_t'(branch_i[i] - msit_pkg::branch_t'(1));
          end
        end
      end
    end
    ok_o = !carry;
  end
endmodule
`default_nettype wire

// File: src/multilevel_sparse_index_table.sv
// Sparse table on a mixed-radix index; one shared stepper and one store port.
// After the input transfer: write, erase, error, unknown kind go straight to the result; read
// waits on the registered store data; find checks up to 65536 entries; clear writes all 65536
// (one entry a cycle). One item at a time: no new input until the result has been taken.
// Reset (async, active low) starts the same clearing pass; no input transfer is taken
// until it ends. Config writes are taken at any time.
`default_nettype none
`include "assert_macros.svh"
module multilevel_sparse_index_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [3:0] digit0, [7:4] digit1, [11:8] digit2, [15:12] digit3,
  // [47:16] entry_value, [48] included, [55:49] zero
  input  wire logic [55:0] s_axis_tdata,
  // [2:0] kind
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [31:0] result_value, [35:32] out_digit0, [39:36] out_digit1,
  // [43:40] out_digit2, [47:44] out_digit3
  output logic [47:0]      m_axis_tdata,
  // [0] found, [1] index_error
  output logic [1:0]       m_axis_tuser
);
  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_RWAIT, ST_SCAN, ST_CHECK, ST_OUT
  } state_e;

  state_e                state_q;
  msit_pkg::addr_t       cnt_q;
  logic                  clr_reply_q;
  msit_pkg::digits_t     dig_q;
  logic                  fwd_q;
  logic                  res_found_q, res_err_q;
  msit_pkg::value_t      res_val_q;
  msit_pkg::digits_t     res_dig_q;
  msit_pkg::level_t      level_q;
  msit_pkg::branches_t   br_q;

  // configuration
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= msit_pkg::level_t'(msit_pkg::MAX_LEVELS);
      br_q    <= {msit_pkg::MAX_LEVELS{msit_pkg::branch_t'(msit_pkg::MAX_BRANCH)}};
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        msit_pkg::REG_LEVELS: level_q <= pwdata[msit_pkg::LVL_BITS-1:0];
        msit_pkg::REG_BR0:    br_q[0] <= pwdata[msit_pkg::BR_BITS-1:0];
        msit_pkg::REG_BR1:    br_q[1] <= pwdata[msit_pkg::BR_BITS-1:0];
        msit_pkg::REG_BR2:    br_q[2] <= pwdata[msit_pkg::BR_BITS-1:0];
        msit_pkg::REG_BR3:    br_q[3] <= pwdata[msit_pkg::BR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      msit_pkg::REG_LEVELS: prdata = 32'(level_q);
      msit_pkg::REG_BR0:    prdata = 32'(br_q[0]);
      msit_pkg::REG_BR1:    prdata = 32'(br_q[1]);
      msit_pkg::REG_BR2:    prdata = 32'(br_q[2]);
      msit_pkg::REG_BR3:    prdata = 32'(br_q[3]);
      default:              prdata = '0;
    endcase
  end

  msit_pkg::level_t    levels;
  msit_pkg::branches_t brs;
  always_comb begin
    levels = msit_pkg::eff_levels(level_q);
    for (int i = 0; i < msit_pkg::MAX_LEVELS; i++) brs[i] = msit_pkg::eff_branch(br_q[i]);
  end

  // input decode
  logic                in_acc;
  logic [2:0]          in_kind;
  msit_pkg::digits_t   in_dig;
  msit_pkg::value_t    in_val;
  logic                in_inc;
  logic                in_err;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign in_kind = s_axis_tuser;
  assign in_val  = s_axis_tdata[47:16];
  assign in_inc  = s_axis_tdata[48];

  always_comb begin
    in_err = 1'b0;
    for (int i = 0; i < msit_pkg::MAX_LEVELS; i++) begin
      if (msit_pkg::level_t'(i) < levels) begin
        in_dig[i] = s_axis_tdata[4*i +: 4];
        if (msit_pkg::branch_t'(in_dig[i]) >= brs[i]) in_err = 1'b1;
      end else begin
        in_dig[i] = '0;
      end
    end
  end

  function automatic msit_pkg::addr_t flat(input msit_pkg::digits_t d);
    return {d[0], d[1], d[2], d[3]};
  endfunction

  // shared stepper
  msit_pkg::digits_t step_in, step_out;
  logic              step_fwd, step_ok;
  assign step_in  = (state_q == ST_IDLE) ? in_dig : dig_q;
  assign step_fwd = (state_q == ST_IDLE) ? (in_kind == msit_pkg::KIND_NEXT) : fwd_q;

  msit_step u_step (
    .dig_i    (step_in),
    .levels_i (levels),
    .branch_i (brs),
    .fwd_i    (step_fwd),
    .dig_o    (step_out),
    .ok_o     (step_ok)
  );

  msit_pkg::digits_t miss_dig;
  always_comb begin
    for (int i = 0; i < msit_pkg::MAX_LEVELS; i++) begin
      miss_dig[i] = (msit_pkg::level_t'(i) < levels && !step_fwd)
                  ? msit_pkg::digit_t'(brs[i] - msit_pkg::branch_t'(1)) : '0;
    end
  end

  // store port
  logic             ram_we;
  msit_pkg::addr_t  ram_addr;
  msit_pkg::value_t ram_wdata, ram_rdata;
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = flat(dig_q);
    ram_wdata = '0;
    case (state_q)
      ST_CLR: begin
        ram_we   = 1'b1;
        ram_addr = cnt_q;
      end
      ST_IDLE: begin
        ram_addr = flat(in_dig);
        if (in_acc && !in_err && (in_kind == msit_pkg::KIND_WRITE ||
                                  in_kind == msit_pkg::KIND_ERASE)) begin
          ram_we    = 1'b1;
          ram_wdata = (in_kind == msit_pkg::KIND_WRITE) ? in_val : '0;
        end
      end
      default: ;
    endcase
  end

  msit_ram #(.AW(msit_pkg::ADDR_BITS), .DW(msit_pkg::VALUE_BITS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      clr_reply_q <= 1'b0;
      dig_q       <= '0;
      fwd_q       <= 1'b0;
      res_found_q <= 1'b0;
      res_err_q   <= 1'b0;
      res_val_q   <= '0;
      res_dig_q   <= '0;
    end else begin
      case (state_q)
        ST_CLR: begin
          cnt_q <= cnt_q + msit_pkg::addr_t'(1);
          if (cnt_q == '1) begin
            state_q     <= clr_reply_q ? ST_OUT : ST_IDLE;
            clr_reply_q <= 1'b0;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            res_found_q <= 1'b0;
            res_err_q   <= 1'b0;
            res_val_q   <= '0;
            res_dig_q   <= '0;
            dig_q       <= in_dig;
            fwd_q       <= (in_kind == msit_pkg::KIND_NEXT);
            state_q     <= ST_OUT;
            if (in_kind == msit_pkg::KIND_CLEAR) begin
              clr_reply_q <= 1'b1;
              cnt_q       <= '0;
              state_q     <= ST_CLR;
            end else if (in_kind > msit_pkg::KIND_CLEAR) begin
              state_q <= ST_OUT;
            end else if (in_err) begin
              res_err_q <= 1'b1;
            end else begin
              case (in_kind)
                msit_pkg::KIND_READ: state_q <= ST_RWAIT;
                msit_pkg::KIND_WRITE: begin
                  res_found_q <= (in_val != '0);
                  res_val_q   <= in_val;
                  res_dig_q   <= in_dig;
                end
                msit_pkg::KIND_ERASE: res_dig_q <= in_dig;
                default: begin
                  if (in_inc) begin
                    state_q <= ST_SCAN;
                  end else if (step_ok) begin
                    dig_q   <= step_out;
                    state_q <= ST_SCAN;
                  end else begin
                    res_dig_q <= miss_dig;
                  end
                end
              endcase
            end
          end
        end
        ST_RWAIT: begin
          res_found_q <= (ram_rdata != '0);
          res_val_q   <= ram_rdata;
          res_dig_q   <= dig_q;
          state_q     <= ST_OUT;
        end
        ST_SCAN: state_q <= ST_CHECK;
        ST_CHECK: begin
          if (ram_rdata != '0) begin
            res_found_q <= 1'b1;
            res_val_q   <= ram_rdata;
            res_dig_q   <= dig_q;
            state_q     <= ST_OUT;
          end else if (step_ok) begin
            dig_q   <= step_out;
            state_q <= ST_SCAN;
          end else begin
            res_dig_q <= miss_dig;
            state_q   <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = {res_dig_q, res_val_q};
  assign m_axis_tuser  = {res_err_q, res_found_q};

  `MSIT_ASSERT(a_one_side, clk_i, rst_ni, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
  `MSIT_ASSERT(a_found_val, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tuser[0] == (m_axis_tdata[31:0] != 32'd0)), "found flag disagrees with value")
  `MSIT_ASSERT(a_err_clean, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == 48'd0), "error result not zero")
  `MSIT_ASSERT(a_busy, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready right after a transfer")
endmodule
`default_nettype wire

// File: tb/multilevel_sparse_index_table_tb.sv
// Testbench for the multilevel sparse index table: random and directed requests
// checked against a behavioral table model. Depends on msit_pkg and the RTL top.
`default_nettype none
module multilevel_sparse_index_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]        kind;
    msit_pkg::digits_t dig;
    msit_pkg::value_t  val;
    logic              incl;
  } req_t;

  typedef struct packed {
    logic              found;
    msit_pkg::value_t  val;
    msit_pkg::digits_t dig;
    logic              err;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [2:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  multilevel_sparse_index_table dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model state
  msit_pkg::value_t table_mem [int unsigned];
  logic [2:0] lvl_reg = 3'd4;
  logic [4:0] br_reg [4] = '{5'd16, 5'd16, 5'd16, 5'd16};

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int unsigned errors = 0, mismatches = 0, n_sent = 0, n_hits = 0;
  longint unsigned cycles = 0;
  bit sender_hold = 1'b0;

  function automatic int unsigned levels_used();
    if (lvl_reg < 1) return 1;
    if (lvl_reg > msit_pkg::MAX_LEVELS) return msit_pkg::MAX_LEVELS;
    return lvl_reg;
  endfunction

  function automatic int unsigned branches(int i);
    if (br_reg[i] < 2) return 2;
    if (br_reg[i] > msit_pkg::MAX_BRANCH) return msit_pkg::MAX_BRANCH;
    return br_reg[i];
  endfunction

  function automatic int unsigned table_addr(int unsigned d[4]);
    return (d[0] << 12) | (d[1] << 8) | (d[2] << 4) | d[3];
  endfunction

  function automatic msit_pkg::value_t table_get(int unsigned a);
    return table_mem.exists(a) ? table_mem[a] : '0;
  endfunction

  // one step in index order, returns 0 on wrap
  function automatic bit step_index(ref int unsigned d[4], input int unsigned lv,
                                    input bit fwd);
    for (int i = lv - 1; i >= 0; i--) begin
      if (fwd) begin
        d[i]++;
        if (d[i] < branches(i)) return 1'b1;
        d[i] = 0;
      end else begin
        if (d[i] > 0) begin
          d[i]--;
          return 1'b1;
        end
        d[i] = branches(i) - 1;
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t table_access(req_t r);
    rsp_t o;
    int unsigned d[4];
    int unsigned lv;
    bit ok, fwd;
    msit_pkg::value_t v;
    o = '0;
    lv = levels_used();
    if (r.kind == msit_pkg::KIND_CLEAR) begin
      table_mem.delete();
      return o;
    end
    if (r.kind > msit_pkg::KIND_CLEAR) return o;
    for (int i = 0; i < 4; i++) d[i] = r.dig[i];
    for (int i = 0; i < lv; i++)
      if (d[i] >= branches(i)) begin
        o.err = 1'b1;
        return o;
      end
    for (int i = lv; i < 4; i++) d[i] = 0;
    v = '0;
    case (r.kind)
      msit_pkg::KIND_READ: v = table_get(table_addr(d));
      msit_pkg::KIND_WRITE: begin
        v = r.val;
        table_mem[table_addr(d)] = v;
      end
      msit_pkg::KIND_ERASE: table_mem.delete(table_addr(d));
      default: begin
        fwd = (r.kind == msit_pkg::KIND_NEXT);
        ok = 1'b1;
        if (!r.incl) ok = step_index(d, lv, fwd);
        while (ok) begin
          v = table_get(table_addr(d));
          if (v != 0) break;
          ok = step_index(d, lv, fwd);
        end
        if (!ok) begin
          v = '0;
          for (int i = 0; i < 4; i++) d[i] = (i < lv && !fwd) ? branches(i) - 1 : 0;
        end
      end
    endcase
    o.found = (v != 0);
    o.val = v;
    for (int i = 0; i < 4; i++) o.dig[i] = msit_pkg::digit_t'(d[i]);
    if (o.found) n_hits++;
    return o;
  endfunction

  function automatic int unsigned rand_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int unsigned send_gap = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rsps.push_back(table_access(pending_reqs.pop_front()));
        n_sent <= n_sent + 1;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the transfer
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!sender_hold && pending_reqs.size() > 0) begin
        req_t r;
        r = pending_reqs[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= r.kind;
        s_axis_tdata <= {7'd0, r.incl, r.val, r.dig[3], r.dig[2], r.dig[1], r.dig[0]};
        send_gap <= rand_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  int unsigned recv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        rsp_t got, want;
        got.found = m_axis_tuser[0];
        got.err = m_axis_tuser[1];
        got.val = m_axis_tdata[31:0];
        got.dig = m_axis_tdata[47:32];
        if (expected_rsps.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %h", got);
        end else begin
          want = expected_rsps.pop_front();
          if (got !== want) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp found=%b val=%h dig=%h err=%b got found=%b val=%h dig=%h err=%b",
                       want.found, want.val, want.dig, want.err,
                       got.found, got.val, got.dig, got.err);
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        recv_gap <= rand_gap();
      end
    end
  end

  always @(posedge clk_i)
    if (cycles > 20000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("** multilevel_sparse_index_table: FAILED **");
      $finish;
    end

  task automatic apb_write(input msit_pkg::reg_e idx, input logic [31:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(idx) << 2; pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == msit_pkg::REG_LEVELS) lvl_reg = v[2:0];
    else br_reg[int'(idx) - 1] = v[4:0];
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic req_t make_req(logic [2:0] k, int unsigned d0, int unsigned d1,
                                    int unsigned d2, int unsigned d3,
                                    msit_pkg::value_t v, bit inc);
    req_t r;
    r.kind = k;
    r.dig[0] = msit_pkg::digit_t'(d0); r.dig[1] = msit_pkg::digit_t'(d1);
    r.dig[2] = msit_pkg::digit_t'(d2); r.dig[3] = msit_pkg::digit_t'(d3);
    r.val = v;
    r.incl = inc;
    return r;
  endfunction

  function automatic logic [3:0] rand_digit(int i);
    if ($urandom_range(0, 19) == 0) return 4'($urandom_range(0, 15));
    if ($urandom_range(0, 3) == 0) return (br_reg[i] > 16) ? 4'd15 : 4'(br_reg[i] - 1);
    return 4'($urandom_range(0, branches(i) - 1));
  endfunction

  task automatic queue_random(int unsigned n);
    req_t r;
    logic [2:0] k;
    int unsigned p;
    for (int j = 0; j < n; j++) begin
      p = $urandom_range(0, 199);
      if (p == 0) k = msit_pkg::KIND_CLEAR;
      else if (p < 3) k = 3'($urandom_range(6, 7));
      else if (p < 60) k = msit_pkg::KIND_WRITE;
      else if (p < 80) k = msit_pkg::KIND_ERASE;
      else if (p < 110) k = msit_pkg::KIND_READ;
      else if (p < 155) k = msit_pkg::KIND_NEXT;
      else k = msit_pkg::KIND_PREV;
      r = make_req(k, rand_digit(0), rand_digit(1), rand_digit(2), rand_digit(3),
                   $urandom_range(0, 9) == 0 ? '0 : msit_pkg::value_t'($urandom()),
                   1'($urandom_range(0, 1)));
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, every kind, wrap and miss cases at full size
    pending_reqs.push_back(make_req(msit_pkg::KIND_NEXT, 0, 0, 0, 0, '0, 1'b1));
    pending_reqs.push_back(make_req(msit_pkg::KIND_WRITE, 15, 15, 15, 15, 32'hFFFFFFFF, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_WRITE, 0, 0, 0, 0, 32'h1, 1'b1));
    pending_reqs.push_back(make_req(msit_pkg::KIND_READ, 15, 15, 15, 15, '0, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_NEXT, 15, 15, 15, 15, '0, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_PREV, 0, 0, 0, 0, '0, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_PREV, 0, 0, 0, 0, '0, 1'b1));
    pending_reqs.push_back(make_req(msit_pkg::KIND_NEXT, 0, 0, 0, 0, '0, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_WRITE, 0, 0, 0, 0, '0, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_ERASE, 15, 15, 15, 15, '0, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_PREV, 15, 15, 15, 15, '0, 1'b1));
    pending_reqs.push_back(make_req(3'd6, 1, 2, 3, 4, 32'h5, 1'b1));
    pending_reqs.push_back(make_req(3'd7, 1, 2, 3, 4, 32'h5, 1'b1));
    pending_reqs.push_back(make_req(msit_pkg::KIND_WRITE, 3, 4, 5, 6, 32'hA5A5_0001, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_CLEAR, 9, 9, 9, 9, '0, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_READ, 3, 4, 5, 6, '0, 1'b0));
    drain();
    // small trees keep finds short
    apb_write(msit_pkg::REG_LEVELS, 2);
    apb_write(msit_pkg::REG_BR0, 5); apb_write(msit_pkg::REG_BR1, 3);
    apb_write(msit_pkg::REG_BR2, 2); apb_write(msit_pkg::REG_BR3, 16);
    pending_reqs.push_back(make_req(msit_pkg::KIND_WRITE, 5, 0, 7, 7, 32'h3, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_WRITE, 4, 3, 0, 0, 32'h3, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_WRITE, 4, 2, 15, 15, 32'h7, 1'b0));
    pending_reqs.push_back(make_req(msit_pkg::KIND_NEXT, 0, 0, 9, 9, '0, 1'b0));
    queue_random(300);
    drain();
    apb_write(msit_pkg::REG_LEVELS, 0); apb_write(msit_pkg::REG_BR0, 31);
    queue_random(200);
    // pause the sender until all results are in
    while (pending_reqs.size() > 100) @(posedge clk_i);
    sender_hold = 1'b1;
    while (s_axis_tvalid || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    sender_hold = 1'b0;
    drain();
    apb_write(msit_pkg::REG_LEVELS, 3); apb_write(msit_pkg::REG_BR0, 2);
    apb_write(msit_pkg::REG_BR1, 0); apb_write(msit_pkg::REG_BR2, 7);
    queue_random(400);
    drain();
    apb_write(msit_pkg::REG_LEVELS, 7); apb_write(msit_pkg::REG_BR0, 3);
    apb_write(msit_pkg::REG_BR1, 2); apb_write(msit_pkg::REG_BR2, 4);
    apb_write(msit_pkg::REG_BR3, 3);
    queue_random(400);
    drain();
    apb_write(msit_pkg::REG_LEVELS, 4); apb_write(msit_pkg::REG_BR0, 16);
    apb_write(msit_pkg::REG_BR1, 2); apb_write(msit_pkg::REG_BR2, 2);
    apb_write(msit_pkg::REG_BR3, 16);
    queue_random(380);
    drain();
    $display("covered %0d requests (%0d hits) over five register settings", n_sent, n_hits);
    if (errors == 0) begin
      $display("** multilevel_sparse_index_table: PASSED **");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("** multilevel_sparse_index_table: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
+incdir+src
src/msit_pkg.sv
src/msit_ram.sv
src/msit_step.sv
src/multilevel_sparse_index_table.sv
tb/multilevel_sparse_index_table_tb.sv
